// ===== hdl/ctb_pkg.sv =====
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared types and constants for the countdown timer bank: command and
// result words, operation codes, controller states and the cell command.
// ----------------------------------------------------------------------------
package ctb_pkg;

	localparam int DUR_W       = 32;
	localparam int TID_W       = 8;
	localparam int FID_W       = 4;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	// operation codes
	localparam logic [2:0] MODE_START   = 3'd0;
	localparam logic [2:0] MODE_STOP    = 3'd1;
	localparam logic [2:0] MODE_QUERY   = 3'd2;
	localparam logic [2:0] MODE_TICK    = 3'd3;
	localparam logic [2:0] MODE_PROCESS = 3'd4;

	typedef struct packed {
		logic [2:0]       mode;
		logic [TID_W-1:0] timer_id;
		logic [DUR_W-1:0] duration;
		logic             want_notify;
	} cmd_t;

	typedef struct packed {
		logic             running;
		logic             bad_id;
		logic             fired;
		logic [FID_W-1:0] fired_id;
		logic             last;
	} res_t;

	// broadcast to every cell; load and clear also need the cell's select
	typedef struct packed {
		logic             load;
		logic             clear;
		logic             tick;
		logic             proc;
		logic [DUR_W-1:0] duration;
		logic             notify;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FLUSH
	} state_t;

endpackage

// ===== hdl/ctb_cell.sv =====
// ----------------------------------------------------------------------------
// ctb_cell
// One timer of the bank: count, active, expired and notify flags, plus one
// stage of the sweep token chain that visits the cells in index order.
// ----------------------------------------------------------------------------
module ctb_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_in,
	input  logic              sel,
	input  ctb_pkg::cell_cmd_t ccmd,
	output logic              tok_out,
	output logic              running,
	output logic              hit
);

	logic [ctb_pkg::DUR_W-1:0] rem_q;
	logic                      count_q;
	logic                      to_q;
	logic                      ntf_q;
	logic                      tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			count_q <= 1'b0;
			to_q    <= 1'b0;
			ntf_q   <= 1'b0;
			tok_q   <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (sel && ccmd.load) begin
				rem_q   <= ccmd.duration;
				to_q    <= 1'b0;
				ntf_q   <= ccmd.notify;
				count_q <= 1'b1;
			end else if (sel && ccmd.clear) begin
				rem_q   <= '0;
				count_q <= 1'b0;
				to_q    <= 1'b0;
			end else if (tok_q && ccmd.tick && count_q && (rem_q != '0)) begin
				rem_q <= rem_q - ctb_pkg::DUR_W'(1);
				// reaching zero: expire and stop
				if (rem_q == ctb_pkg::DUR_W'(1)) begin
					count_q <= 1'b0;
					to_q    <= 1'b1;
				end
			end else if (tok_q && ccmd.proc) begin
				to_q <= 1'b0;
			end
		end
	end

	assign tok_out = tok_q;
	assign running = count_q && !to_q;
	assign hit     = tok_q && ccmd.proc && to_q && ntf_q;

endmodule

// ===== hdl/countdown_timer_bank_top.sv =====
// ----------------------------------------------------------------------------
// countdown_timer_bank_top
// Bank of countdown timers built as a row of timer cells with a sweep token
// that steps one cell per cycle, plus the command decode and result register.
// ----------------------------------------------------------------------------
// start, stop, query and unused codes: one word, in the cycle after acceptance;
//   busy stays low, so such commands may follow in every cycle
// tick and process: busy while the token walks the cell row and in the flush
//   state; process words leave during the walk, the last one in the first
//   cycle with busy low again, so a new sweep is taken only from then on
// reset (asynchronous, active low) clears every timer and the controller
module countdown_timer_bank_top #(
	parameter int NUM_TIMERS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ctb_pkg::cmd_t cmd,
	output logic          strobe,
	output ctb_pkg::res_t result
);

	// sweep position width, at least one bit
	localparam int POS_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_TIMERS - 1);

	ctb_pkg::state_t    state_q, state_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [2:0]         mode_q;
	logic               pend_q, pend_d;
	logic [ctb_pkg::FID_W-1:0] pend_id_q, pend_id_d;
	logic [ctb_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic               strobe_q, strobe_d;
	ctb_pkg::res_t      res_q, res_d;

	logic               accept;
	logic               valid_id;
	logic               launch;
	logic               any_hit;
	logic [7:0]         pos_wide;
	ctb_pkg::cell_cmd_t ccmd;

	logic [NUM_TIMERS-1:0] tok_vec;
	logic [NUM_TIMERS-1:0] run_vec;
	logic [NUM_TIMERS-1:0] hit_vec;
	logic [NUM_TIMERS-1:0] sel_vec;

	assign accept   = start && !busy;
	assign valid_id = ({1'b0, cmd.timer_id} < 9'(NUM_TIMERS));
	// tick and process both walk the whole row
	assign launch   = accept && ((cmd.mode == ctb_pkg::MODE_TICK) ||
	                             (cmd.mode == ctb_pkg::MODE_PROCESS));
	assign any_hit  = |hit_vec;
	assign pos_wide = 8'(pos_q);

	// broadcast command for the row
	always_comb begin
		ccmd.load     = accept && valid_id && (cmd.mode == ctb_pkg::MODE_START);
		ccmd.clear    = accept && valid_id && (cmd.mode == ctb_pkg::MODE_STOP);
		ccmd.tick     = (state_q == ctb_pkg::ST_SWEEP) && (mode_q == ctb_pkg::MODE_TICK);
		ccmd.proc     = (state_q == ctb_pkg::ST_SWEEP) && (mode_q == ctb_pkg::MODE_PROCESS);
		ccmd.duration = cmd.duration;
		ccmd.notify   = cmd.want_notify;
	end

	// row of timer cells, token enters at cell zero
	for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
		assign sel_vec[i] = (cmd.timer_id == 8'(i));
		ctb_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  ((i == 0) ? launch : tok_vec[(i == 0) ? 0 : i - 1]),
			.sel     (sel_vec[i]),
			.ccmd    (ccmd),
			.tok_out (tok_vec[i]),
			.running (run_vec[i]),
			.hit     (hit_vec[i])
		);
	end

	// controller: next state and result word
	always_comb begin
		state_d   = state_q;
		pos_d     = pos_q;
		pend_d    = pend_q;
		pend_id_d = pend_id_q;
		cnt_d     = cnt_q;
		strobe_d  = 1'b0;
		res_d     = '0;
		unique case (state_q)
			ctb_pkg::ST_IDLE: begin
				if (launch) begin
					state_d = ctb_pkg::ST_SWEEP;
					pos_d   = '0;
					pend_d  = 1'b0;
					cnt_d   = '0;
				end else if (accept) begin
					strobe_d   = 1'b1;
					res_d.last = 1'b1;
					if ((cmd.mode == ctb_pkg::MODE_START) ||
					    (cmd.mode == ctb_pkg::MODE_STOP) ||
					    (cmd.mode == ctb_pkg::MODE_QUERY)) begin
						res_d.bad_id  = !valid_id;
						res_d.running = valid_id && (cmd.mode == ctb_pkg::MODE_QUERY) &&
						                run_vec[cmd.timer_id[POS_W-1:0]];
					end
				end
			end
			ctb_pkg::ST_SWEEP: begin
				// hold one found timer back so the final one can carry last
				if (any_hit && (cnt_q < ctb_pkg::CNT_W'(ctb_pkg::MAX_RESULTS))) begin
					if (pend_q) begin
						strobe_d       = 1'b1;
						res_d.fired    = 1'b1;
						res_d.fired_id = pend_id_q;
					end
					pend_d    = 1'b1;
					pend_id_d = pos_wide[ctb_pkg::FID_W-1:0];
					cnt_d     = cnt_q + ctb_pkg::CNT_W'(1);
				end
				if (pos_q == POS_LAST) begin
					state_d = ctb_pkg::ST_FLUSH;
				end else begin
					pos_d = pos_q + POS_W'(1);
				end
			end
			ctb_pkg::ST_FLUSH: begin
				strobe_d   = 1'b1;
				res_d.last = 1'b1;
				if (pend_q) begin
					res_d.fired    = 1'b1;
					res_d.fired_id = pend_id_q;
				end
				pend_d  = 1'b0;
				state_d = ctb_pkg::ST_IDLE;
			end
			default: begin
				state_d = ctb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ctb_pkg::ST_IDLE;
			pos_q    <= '0;
			pend_q   <= 1'b0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			pos_q    <= pos_d;
			pend_q   <= pend_d;
			cnt_q    <= cnt_d;
			strobe_q <= strobe_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		res_q     <= res_d;
		pend_id_q <= pend_id_d;
		if (launch) begin
			mode_q <= cmd.mode;
		end
	end

	assign busy   = (state_q != ctb_pkg::ST_IDLE);
	assign strobe = strobe_q;
	assign result = res_q;

	// at most one cell holds the sweep token
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one sweep token in the cell row");

	// token position matches the sweep counter
	a_tok_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ctb_pkg::ST_SWEEP) |-> tok_vec[pos_q])
		else $error("sweep token out of step with position counter");

	// the flush cycle always closes a sweep with a last word
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ctb_pkg::ST_FLUSH) |=> (strobe && result.last))
		else $error("sweep ended without a last word");

	// a word without last only ever names a fired timer
	a_mid_fired: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last) |-> result.fired)
		else $error("intermediate word without a fired timer");

	// single-slot commands answer in the next cycle
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && ((cmd.mode == ctb_pkg::MODE_START) ||
		                    (cmd.mode == ctb_pkg::MODE_STOP) ||
		                    (cmd.mode == ctb_pkg::MODE_QUERY)))
		|=> (strobe && result.last && !busy))
		else $error("single-slot command did not answer in one cycle");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the countdown timer bank. A short directed table
// walks the reset state, the index extremes, unused codes, zero and maximum
// durations and expiry reporting. Constrained-by-hand random command streams
// with idle bursts and a full-bank expiry follow. Every returned word is
// compared field by field with its typed row or a behavioural store copy.
// ----------------------------------------------------------------------------
module tb;

	localparam int NUM_TIMERS   = 16;
	localparam int RANDOM_WORDS = 386;
	localparam int QUIET_TAIL   = 60;

	typedef struct {
		ctb_pkg::cmd_t c;
		bit            typed;
		ctb_pkg::res_t want;
	} stim_row_t;

	logic          clk    = 1'b0;
	logic          arst_n = 1'b0;
	logic          start  = 1'b0;
	ctb_pkg::cmd_t cmd    = '0;
	logic          busy;
	logic          strobe;
	ctb_pkg::res_t result;

	// behavioural copy of the timer store
	logic [ctb_pkg::DUR_W-1:0] tmr_left   [NUM_TIMERS] = '{default: '0};
	bit                        tmr_active [NUM_TIMERS] = '{default: 1'b0};
	bit                        tmr_expired[NUM_TIMERS] = '{default: 1'b0};
	bit                        tmr_notify [NUM_TIMERS] = '{default: 1'b0};

	ctb_pkg::res_t pending_words[$];
	stim_row_t     dir_rows[$];

	int  mismatches    = 0;
	int  issued_cmds   = 0;
	int  useful_cmds   = 0;
	int  words_checked = 0;
	int  expiries_seen = 0;
	int  full_sweeps   = 0;
	bit  idle_on       = 1'b1;

	countdown_timer_bank_top #(
		.NUM_TIMERS(NUM_TIMERS)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.strobe(strobe),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic ctb_pkg::cmd_t mk_cmd(input logic [2:0] m,
			input logic [ctb_pkg::TID_W-1:0] id,
			input logic [ctb_pkg::DUR_W-1:0] d, input logic nt);
		ctb_pkg::cmd_t c;
		c.mode        = m;
		c.timer_id    = id;
		c.duration    = d;
		c.want_notify = nt;
		return c;
	endfunction

	function automatic ctb_pkg::res_t word_of(input logic run, input logic bad,
			input logic fire, input logic [ctb_pkg::FID_W-1:0] fid, input logic lst);
		ctb_pkg::res_t w;
		w.running  = run;
		w.bad_id   = bad;
		w.fired    = fire;
		w.fired_id = fid;
		w.last     = lst;
		return w;
	endfunction

	function automatic void add_row(input ctb_pkg::cmd_t c, input bit typed,
			input ctb_pkg::res_t want);
		stim_row_t r;
		r.c     = c;
		r.typed = typed;
		r.want  = want;
		dir_rows.push_back(r);
	endfunction

	// apply one command to the store copy and return the words it should produce
	function automatic void advance_bank(input ctb_pkg::cmd_t c,
			ref ctb_pkg::res_t words[$]);
		ctb_pkg::res_t w;
		int            tid;
		int            i;
		int            n;
		words    = {};
		w        = '0;
		w.last   = 1'b1;
		tid      = int'(c.timer_id);
		case (c.mode) inside
			ctb_pkg::MODE_START, ctb_pkg::MODE_STOP, ctb_pkg::MODE_QUERY: begin
				if (tid >= NUM_TIMERS) begin
					w.bad_id = 1'b1;
				end else if (c.mode == ctb_pkg::MODE_START) begin
					tmr_left[tid]    = c.duration;
					tmr_expired[tid] = 1'b0;
					tmr_notify[tid]  = c.want_notify;
					tmr_active[tid]  = 1'b1;
				end else if (c.mode == ctb_pkg::MODE_STOP) begin
					tmr_left[tid]    = '0;
					tmr_active[tid]  = 1'b0;
					tmr_expired[tid] = 1'b0;
				end else begin
					w.running = tmr_active[tid] && !tmr_expired[tid];
				end
				words.push_back(w);
			end
			ctb_pkg::MODE_TICK: begin
				// a zero count never moves, so a zero-duration timer runs for ever
				for (i = 0; i < NUM_TIMERS; i++) begin
					if (tmr_active[i] && tmr_left[i] != '0) begin
						tmr_left[i] = tmr_left[i] - 1'b1;
						if (tmr_left[i] == '0) begin
							tmr_active[i]  = 1'b0;
							tmr_expired[i] = 1'b1;
						end
					end
				end
				words.push_back(w);
			end
			ctb_pkg::MODE_PROCESS: begin
				n = 0;
				for (i = 0; i < NUM_TIMERS; i++) begin
					if (tmr_expired[i]) begin
						tmr_expired[i] = 1'b0;
						if (tmr_notify[i] && n < ctb_pkg::MAX_RESULTS) begin
							words.push_back(word_of(1'b0, 1'b0, 1'b1,
								i[ctb_pkg::FID_W-1:0], 1'b0));
							n++;
						end
					end
				end
				if (n == 0)
					words.push_back(w);
				else
					words[n-1].last = 1'b1;
			end
			default: begin
				words.push_back(w);
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [3:0] got,
			input logic [3:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// hand one command to the bank and book its expected words
	task automatic issue_word(input ctb_pkg::cmd_t c, input bit typed,
			input ctb_pkg::res_t want);
		ctb_pkg::res_t words[$];
		cmd   <= c;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		advance_bank(c, words);
		if (typed)
			words = {want};
		foreach (words[k])
			pending_words.push_back(words[k]);
		issued_cmds++;
		if (!(c.mode > ctb_pkg::MODE_PROCESS ||
		      (c.mode <= ctb_pkg::MODE_QUERY && c.timer_id >= NUM_TIMERS)))
			useful_cmds++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic hold_until_drained();
		start <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	// result side: no back-pressure, every strobe is a word to check
	always @(posedge clk) begin
		ctb_pkg::res_t w;
		if (arst_n && strobe) begin
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("word with nothing expected: %p", result));
			end else begin
				w = pending_words.pop_front();
				check_field("running", 4'(result.running), 4'(w.running));
				check_field("bad_id", 4'(result.bad_id), 4'(w.bad_id));
				check_field("fired", 4'(result.fired), 4'(w.fired));
				check_field("fired_id", 4'(result.fired_id), 4'(w.fired_id));
				check_field("last", 4'(result.last), 4'(w.last));
				words_checked++;
				if (w.fired)
					expiries_seen++;
			end
		end
	end

	initial begin
		int   target;
		int   r;
		int   i;
		logic [ctb_pkg::DUR_W-1:0] d;

		// directed table: typed expectations only where obvious at a glance
		add_row(mk_cmd(ctb_pkg::MODE_QUERY, 8'd0, '0, 1'b0), 1'b1,
			word_of(1'b0, 1'b0, 1'b0, 4'd0, 1'b1));
		add_row(mk_cmd(ctb_pkg::MODE_PROCESS, 8'd0, '0, 1'b0), 1'b1,
			word_of(1'b0, 1'b0, 1'b0, 4'd0, 1'b1));
		add_row(mk_cmd(ctb_pkg::MODE_QUERY, 8'd255, '1, 1'b1), 1'b1,
			word_of(1'b0, 1'b1, 1'b0, 4'd0, 1'b1));
		add_row(mk_cmd(ctb_pkg::MODE_START, 8'd16, 32'd5, 1'b1), 1'b1,
			word_of(1'b0, 1'b1, 1'b0, 4'd0, 1'b1));
		add_row(mk_cmd(ctb_pkg::MODE_STOP, 8'd200, '0, 1'b0), 1'b1,
			word_of(1'b0, 1'b1, 1'b0, 4'd0, 1'b1));
		add_row(mk_cmd(3'd5, 8'd3, 32'd7, 1'b1), 1'b1,
			word_of(1'b0, 1'b0, 1'b0, 4'd0, 1'b1));
		add_row(mk_cmd(3'd7, 8'd255, '1, 1'b1), 1'b1,
			word_of(1'b0, 1'b0, 1'b0, 4'd0, 1'b1));
		add_row(mk_cmd(ctb_pkg::MODE_START, 8'd0, 32'd1, 1'b1), 1'b1,
			word_of(1'b0, 1'b0, 1'b0, 4'd0, 1'b1));
		// zero duration: runs for ever
		add_row(mk_cmd(ctb_pkg::MODE_START, 8'd15, '0, 1'b1), 1'b0, '0);
		add_row(mk_cmd(ctb_pkg::MODE_START, 8'd5, '1, 1'b0), 1'b0, '0);
		// expires without a notify bit, so process stays quiet about it
		add_row(mk_cmd(ctb_pkg::MODE_START, 8'd3, 32'd2, 1'b0), 1'b0, '0);
		add_row(mk_cmd(ctb_pkg::MODE_START, 8'd7, 32'd2, 1'b1), 1'b0, '0);
		add_row(mk_cmd(ctb_pkg::MODE_QUERY, 8'd0, '0, 1'b0), 1'b0, '0);
		add_row(mk_cmd(ctb_pkg::MODE_TICK, 8'd0, '0, 1'b0), 1'b1,
			word_of(1'b0, 1'b0, 1'b0, 4'd0, 1'b1));
		add_row(mk_cmd(ctb_pkg::MODE_QUERY, 8'd0, '0, 1'b0), 1'b0, '0);
		add_row(mk_cmd(ctb_pkg::MODE_QUERY, 8'd15, '0, 1'b0), 1'b0, '0);
		add_row(mk_cmd(ctb_pkg::MODE_TICK, 8'd9, '1, 1'b1), 1'b0, '0);
		add_row(mk_cmd(ctb_pkg::MODE_PROCESS, 8'd0, '0, 1'b0), 1'b0, '0);
		add_row(mk_cmd(ctb_pkg::MODE_PROCESS, 8'd0, '0, 1'b0), 1'b0, '0);
		// a stopped timer never reports
		add_row(mk_cmd(ctb_pkg::MODE_START, 8'd9, 32'd1, 1'b1), 1'b0, '0);
		add_row(mk_cmd(ctb_pkg::MODE_STOP, 8'd9, '0, 1'b0), 1'b0, '0);
		add_row(mk_cmd(ctb_pkg::MODE_TICK, 8'd0, '0, 1'b0), 1'b0, '0);
		add_row(mk_cmd(ctb_pkg::MODE_PROCESS, 8'd0, '0, 1'b0), 1'b0, '0);
		add_row(mk_cmd(3'd6, 8'd240, 32'h8000_0001, 1'b0), 1'b1,
			word_of(1'b0, 1'b0, 1'b0, 4'd0, 1'b1));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k])
			issue_word(dir_rows[k].c, dir_rows[k].typed, dir_rows[k].want);

		// let the bank go completely quiet once
		hold_until_drained();

		target = issued_cmds + RANDOM_WORDS;
		while (issued_cmds < target) begin
			// idle stretches switch on and off; none at all near the end
			if (issued_cmds >= target - QUIET_TAIL)
				idle_on = 1'b0;
			else if (issued_cmds % 25 == 0)
				idle_on = ($urandom_range(0, 2) != 0);

			r = $urandom_range(0, 99);
			if (r < 30) begin
				case ($urandom_range(0, 9))
					0:       d = '0;
					1:       d = $urandom;
					default: d = $urandom_range(1, 5);
				endcase
				issue_word(mk_cmd(ctb_pkg::MODE_START, 8'($urandom_range(0, NUM_TIMERS-1)),
					d, 1'($urandom_range(0, 1))), 1'b0, '0);
			end else if (r < 38) begin
				issue_word(mk_cmd(ctb_pkg::MODE_STOP, 8'($urandom_range(0, NUM_TIMERS-1)),
					$urandom, 1'($urandom_range(0, 1))), 1'b0, '0);
			end else if (r < 52) begin
				issue_word(mk_cmd(ctb_pkg::MODE_QUERY, 8'($urandom_range(0, NUM_TIMERS-1)),
					$urandom, 1'($urandom_range(0, 1))), 1'b0, '0);
			end else if (r < 72) begin
				issue_word(mk_cmd(ctb_pkg::MODE_TICK, 8'($urandom_range(0, 255)),
					$urandom, 1'($urandom_range(0, 1))), 1'b0, '0);
			end else if (r < 83) begin
				issue_word(mk_cmd(ctb_pkg::MODE_PROCESS, 8'($urandom_range(0, 255)),
					$urandom, 1'($urandom_range(0, 1))), 1'b0, '0);
			end else if (r < 88) begin
				// out-of-range index on an indexed command
				issue_word(mk_cmd(3'($urandom_range(0, 2)),
					8'($urandom_range(NUM_TIMERS, 255)),
					$urandom, 1'($urandom_range(0, 1))), 1'b0, '0);
			end else if (r < 91) begin
				issue_word(mk_cmd(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)),
					$urandom, 1'($urandom_range(0, 1))), 1'b0, '0);
			end else if (r < 95) begin
				// whole bank expires together: the longest process burst
				for (i = 0; i < NUM_TIMERS; i++)
					issue_word(mk_cmd(ctb_pkg::MODE_START, 8'(i),
						32'($urandom_range(1, 2)), 1'b1), 1'b0, '0);
				repeat (2)
					issue_word(mk_cmd(ctb_pkg::MODE_TICK, 8'd0, '0, 1'b0), 1'b0, '0);
				issue_word(mk_cmd(ctb_pkg::MODE_PROCESS, 8'd0, '0, 1'b0), 1'b0, '0);
				full_sweeps++;
			end else if (r < 97) begin
				hold_until_drained();
			end else begin
				// noise over every field
				issue_word(mk_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
					$urandom, 1'($urandom_range(0, 1))), 1'b0, '0);
			end
		end

		start <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (NUM_TIMERS + 4) @(posedge clk);

		$display("covered %0d commands (%0d acting on the bank), %0d full-bank expiries",
			issued_cmds, useful_cmds, full_sweeps);
		$display("checked %0d words, %0d of them expiry notices, %0d mismatches",
			words_checked, expiries_seen, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== countdown_timer_bank_top.f =====
hdl/ctb_pkg.sv
hdl/ctb_cell.sv
hdl/countdown_timer_bank_top.sv
tb/sv/tb.sv
